// ----- design/lllw_pkg.sv -----
// ----------------------------------------------------------------------------
// lllw_pkg
// Shared types, sizes and helpers for the least-loaded worker registry.
// ----------------------------------------------------------------------------
package lllw_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int LOAD_BITS   = 16;
    localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    localparam int REQ_W      = 2;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int OUT_LOAD_W = 16;

    localparam int S_TDATA_W = ((IP_W + PORT_W + 7) / 8) * 8;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = ((IP_W + PORT_W + OUT_LOAD_W + 7) / 8) * 8;
    localparam int M_TUSER_W = STATUS_W;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [LOAD_BITS-1:0] load_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_DEREGISTER = 2'd1,
        REQ_LOOKUP     = 2'd2
    } req_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        load_t             load;
    } entry_t;

    // Running minimum that ripples down the chain behind a token.
    typedef struct packed {
        logic  tok;
        logic  found;
        load_t load;
        idx_t  idx;
    } carry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic              start;
        logic              do_append;
        logic              do_remove;
        logic              do_bump;
        idx_t              sel_idx;
    } cmd_t;

    // Summary of the chain back to the controller.
    typedef struct packed {
        logic              any_match;
        logic              full;
        carry_t            best;
        logic [IP_W-1:0]   sel_ip;
        logic [PORT_W-1:0] sel_port;
    } chain_stat_t;

    function automatic load_t sat_inc(input load_t l);
        return (l == {LOAD_BITS{1'b1}}) ? l : l + load_t'(1);
    endfunction

    function automatic logic [OUT_LOAD_W-1:0] to_out_load(input load_t l);
        logic [LOAD_BITS+OUT_LOAD_W-1:0] w;
        w = {{OUT_LOAD_W{1'b0}}, l};
        return w[OUT_LOAD_W-1:0];
    endfunction

endpackage

// ----- design/lllw_cell.sv -----
// ----------------------------------------------------------------------------
// lllw_cell
// One table slot: holds an entry, matches it, and forwards the min carry.
// ----------------------------------------------------------------------------
module lllw_cell
    import lllw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  idx_t   cell_idx,
    input  cmd_t   cmd,
    input  logic   left_valid,
    input  logic   left_hit,
    input  carry_t carry_in,
    input  logic   right_valid,
    input  entry_t right_entry,
    output logic   valid,
    output entry_t entry,
    output logic   hit_out,
    output carry_t carry_out
);

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    carry_t carry_reg, carry_next;
    logic   match;
    logic   shift;

    assign match   = valid_reg && (entry_reg.ip == cmd.ip) && (entry_reg.port == cmd.port);
    assign hit_out = left_hit | match;
    assign shift   = cmd.do_remove && (left_hit || match);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.do_append && !valid_reg && left_valid)
        begin
            // first free slot takes the new worker
            valid_next      = 1'b1;
            entry_next.ip   = cmd.ip;
            entry_next.port = cmd.port;
            entry_next.load = '0;
        end
        else if (shift)
        begin
            // close the gap: pull the right neighbor in
            valid_next = right_valid;
            entry_next = right_entry;
        end
        else if (cmd.do_bump && (cmd.sel_idx == cell_idx))
        begin
            entry_next.load = sat_inc(entry_reg.load);
        end
    end

    always_comb
    begin
        carry_next = carry_in;
        if (carry_in.tok && valid_reg
            && (!carry_in.found || (entry_reg.load < carry_in.load)))
        begin
            carry_next.found = 1'b1;
            carry_next.load  = entry_reg.load;
            carry_next.idx   = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid     = valid_reg;
    assign entry     = entry_reg;
    assign carry_out = carry_reg;

endmodule

// ----- design/lllw_ctrl.sv -----
// ----------------------------------------------------------------------------
// lllw_ctrl
// Request sequencer: takes a beat, drives the cells, builds the result beat.
// ----------------------------------------------------------------------------
module lllw_ctrl
    import lllw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output cmd_t                 cmd,
    input  chain_stat_t          stat,
    input  logic                 empty
);

    state_t                state_reg, state_next;
    logic [REQ_W-1:0]      req_reg;
    logic [IP_W-1:0]       ip_reg;
    logic [PORT_W-1:0]     port_reg;
    logic                  best_found_reg;
    load_t                 best_load_reg;
    idx_t                  best_idx_reg;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [IP_W-1:0]       fip_reg, fip_next;
    logic [PORT_W-1:0]     fport_reg, fport_next;
    logic [OUT_LOAD_W-1:0] fload_reg, fload_next;
    logic                  accept;
    logic                  commit;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == S_DONE) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = (s_tuser == REQ_LOOKUP) ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (stat.best.tok)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready      = (state_reg == S_IDLE);
        cmd.ip        = ip_reg;
        cmd.port      = port_reg;
        cmd.start     = accept && (s_tuser == REQ_LOOKUP);
        cmd.do_append = 1'b0;
        cmd.do_remove = 1'b0;
        cmd.do_bump   = 1'b0;
        cmd.sel_idx   = best_idx_reg;
        status_next   = ST_NOTFOUND;
        fip_next      = '0;
        fport_next    = '0;
        fload_next    = '0;
        unique case (req_reg)
            REQ_REGISTER:
            begin
                if (stat.any_match)
                    status_next = ST_DUP;
                else if (stat.full)
                    status_next = ST_FULL;
                else
                begin
                    status_next   = ST_OK;
                    cmd.do_append = commit;
                end
            end
            REQ_DEREGISTER:
            begin
                if (stat.any_match)
                begin
                    status_next   = ST_OK;
                    cmd.do_remove = commit;
                end
            end
            REQ_LOOKUP:
            begin
                if (!best_found_reg || empty)
                    status_next = ST_EMPTY;
                else
                begin
                    status_next = ST_OK;
                    cmd.do_bump = commit;
                    fip_next    = stat.sel_ip;
                    fport_next  = stat.sel_port;
                    fload_next  = to_out_load(sat_inc(best_load_reg));
                end
            end
            default: status_next = ST_NOTFOUND;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            ip_reg   <= s_tdata[IP_W-1:0];
            port_reg <= s_tdata[IP_W+PORT_W-1:IP_W];
        end
        if (state_reg == S_SCAN && stat.best.tok)
        begin
            best_found_reg <= stat.best.found;
            best_load_reg  <= stat.best.load;
            best_idx_reg   <= stat.best.idx;
        end
        if (commit)
        begin
            status_reg <= status_next;
            fip_reg    <= fip_next;
            fport_reg  <= fport_next;
            fload_reg  <= fload_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_TDATA_W - IP_W - PORT_W - OUT_LOAD_W){1'b0}},
                       fload_reg, fport_reg, fip_reg};

endmodule

// ----- design/least_loaded_worker_registry.sv -----
// ----------------------------------------------------------------------------
// least_loaded_worker_registry
// Table of workers (address, port, load) with register, deregister and
// least-loaded lookup, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request beat on the slave side yields exactly one result beat on the
// master side. A register or deregister request (and the unused request
// code) goes from taking the beat straight to the done state, in which every
// cell compares its entry against the request in parallel and the table is
// updated. A lookup passes a scan state first: the least-loaded search is a
// token carrying the running minimum that moves one cell per clock down the
// chain, so the scan's length is set by the number of cells. One request is
// in flight at a time; the next beat is taken while the previous result
// still waits in the output register. Reset clears the slot valid bits,
// carries and controller state but not the entries, so the table is usable
// as soon as reset is released. Entries stay packed at the low cells in
// arrival order; a removal shifts every later entry one cell toward the head.
module least_loaded_worker_registry
    import lllw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // ip_address[31:0], port_number[47:32]
    input  logic [S_TUSER_W-1:0] s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // found_ip[31:0], found_port[47:32],
                                            // found_load[63:48]
    output logic [M_TUSER_W-1:0] m_tuser    // status[2:0]
);

    cmd_t        cmd;
    chain_stat_t stat;
    logic        cell_valid [MAX_WORKERS];
    entry_t      cell_entry [MAX_WORKERS];
    logic        cell_hit   [MAX_WORKERS];
    carry_t      cell_carry [MAX_WORKERS];
    carry_t      head_carry;
    entry_t      sel_entry;

    // inject the search token at the head of the chain
    always_comb
    begin
        head_carry       = '0;
        head_carry.tok   = cmd.start;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WORKERS; gi++)
        begin : g_cell
            logic   lv, lh, rv;
            carry_t ci;
            entry_t re;

            if (gi == 0)
            begin : g_head
                assign lv = 1'b1;
                assign lh = 1'b0;
                assign ci = head_carry;
            end
            else
            begin : g_body
                assign lv = cell_valid[gi-1];
                assign lh = cell_hit[gi-1];
                assign ci = cell_carry[gi-1];
            end

            if (gi == MAX_WORKERS - 1)
            begin : g_tail
                assign rv = 1'b0;
                assign re = '0;
            end
            else
            begin : g_inner
                assign rv = cell_valid[gi+1];
                assign re = cell_entry[gi+1];
            end

            lllw_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cell_idx    (idx_t'(gi)),
                .cmd         (cmd),
                .left_valid  (lv),
                .left_hit    (lh),
                .carry_in    (ci),
                .right_valid (rv),
                .right_entry (re),
                .valid       (cell_valid[gi]),
                .entry       (cell_entry[gi]),
                .hit_out     (cell_hit[gi]),
                .carry_out   (cell_carry[gi])
            );
        end
    endgenerate

    // select the winning entry for the result beat
    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < MAX_WORKERS; i++)
        begin
            if (cmd.sel_idx == idx_t'(i))
                sel_entry = cell_entry[i];
        end
    end

    always_comb
    begin
        stat.any_match = cell_hit[MAX_WORKERS-1];
        stat.full      = cell_valid[MAX_WORKERS-1];
        stat.best      = cell_carry[MAX_WORKERS-1];
        stat.sel_ip    = sel_entry.ip;
        stat.sel_port  = sel_entry.port;
    end

    lllw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .empty    (!cell_valid[0])
    );

endmodule

// ----- test/least_loaded_worker_registry_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_loaded_worker_registry_test
// Self-checking bench: request beats go in on the slave side and every result
// beat is checked field by field against a behavioral copy of the table.
// ----------------------------------------------------------------------------
// A short scripted sequence runs first: empty table, extreme addresses and
// ports, duplicates, a full table, removals and the unused request code.
// A soak phase then keeps looking up a single worker so its load climbs
// step by step. A random phase follows, built mostly from a small roster of
// known workers so that duplicates, removals that hit and a full table come
// up often. Both sides idle at random, except in stretches where neither
// side idles.
// ----------------------------------------------------------------------------
module least_loaded_worker_registry_test;
    import lllw_pkg::*;

    localparam int                 IDLE_PCT     = 22;
    localparam int                 RANDOM_BEATS = 1850;
    localparam int                 SOAK_LOOKUPS = 64;
    localparam int                 ROSTER_SIZE  = 24;
    localparam int                 DRAIN_CYCLES = 4 * MAX_WORKERS + 16;
    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 PRINT_LIMIT  = 40;
    localparam logic [REQ_W-1:0]   REQ_UNUSED   = 2'd3;

    // One result beat as the block should present it.
    typedef struct {
        status_e                 status;
        logic [IP_W-1:0]         ip;
        logic [PORT_W-1:0]       port;
        logic [OUT_LOAD_W-1:0]   load;
    } reply_t;

    // One row of the scripted sequence. A row with reps > 1 repeats the
    // request with the address stepping up by one each time.
    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        int                reps;
        bit                typed;
        reply_t            want;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow of the worker table, kept packed in arrival order.
    logic [IP_W-1:0]   worker_ip   [MAX_WORKERS];
    logic [PORT_W-1:0] worker_port [MAX_WORKERS];
    load_t             worker_load [MAX_WORKERS];
    int                worker_count = 0;

    reply_t            pending_replies [$];
    reply_t            blank_reply = '{ST_OK, '0, '0, '0};
    int                error_count = 0;
    int                cycle_count = 0;
    bit                calm = 1'b0;

    logic [IP_W-1:0]   roster_ip   [ROSTER_SIZE];
    logic [PORT_W-1:0] roster_port [ROSTER_SIZE];

    least_loaded_worker_registry dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Apply one request to the shadow table and return the result it earns.
    function automatic reply_t registry_apply(input logic [REQ_W-1:0] req,
                                              input logic [IP_W-1:0] ip,
                                              input logic [PORT_W-1:0] port);
        reply_t r;
        int     hit;
        int     best;
        int     i;
        r = '{ST_NOTFOUND, '0, '0, '0};
        hit = -1;
        for (i = worker_count - 1; i >= 0; i--)
        begin
            if (worker_ip[i] == ip && worker_port[i] == port)
                hit = i;
        end
        case (req)
            REQ_REGISTER:
            begin
                // The duplicate check wins over a full table.
                if (hit >= 0)
                    r.status = ST_DUP;
                else if (worker_count >= MAX_WORKERS)
                    r.status = ST_FULL;
                else
                begin
                    worker_ip[worker_count]   = ip;
                    worker_port[worker_count] = port;
                    worker_load[worker_count] = '0;
                    worker_count++;
                    r.status = ST_OK;
                end
            end
            REQ_DEREGISTER:
            begin
                if (hit >= 0)
                begin
                    // Close the gap so later entries keep their order.
                    for (i = hit; i + 1 < worker_count; i++)
                    begin
                        worker_ip[i]   = worker_ip[i + 1];
                        worker_port[i] = worker_port[i + 1];
                        worker_load[i] = worker_load[i + 1];
                    end
                    worker_count--;
                    r.status = ST_OK;
                end
            end
            REQ_LOOKUP:
            begin
                if (worker_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // Strict less-than keeps the earliest entry on a tie.
                    best = 0;
                    for (i = 1; i < worker_count; i++)
                    begin
                        if (worker_load[i] < worker_load[best])
                            best = i;
                    end
                    if (worker_load[best] != {LOAD_BITS{1'b1}})
                        worker_load[best] = worker_load[best] + 1'b1;
                    r.status = ST_OK;
                    r.ip     = worker_ip[best];
                    r.port   = worker_port[best];
                    r.load   = OUT_LOAD_W'(worker_load[best]);
                end
            end
            default:
                r.status = ST_NOTFOUND;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    // Present one request beat and hold it until the block takes it. Called
    // and returns at a falling edge. Valid is left high: the next call
    // either keeps it up or drops it for a gap.
    task automatic issue_request(input logic [REQ_W-1:0] req,
                                 input logic [IP_W-1:0] ip,
                                 input logic [PORT_W-1:0] port,
                                 input bit typed, input reply_t want);
        reply_t model;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= S_TUSER_W'(req);
        s_tdata  <= S_TDATA_W'({port, ip});
        do
            @(posedge clk);
        while (!s_tready);
        model = registry_apply(req, ip, port);
        pending_replies.push_back(typed ? want : model);
        @(negedge clk);
    endtask

    // Result side: stall at random, except while calm.
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
                flag_mismatch("unexpected result beat, status", 32'(m_tuser), 32'hx);
            else
            begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.status)
                    flag_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[IP_W-1:0] !== want.ip)
                    flag_mismatch("found_ip", m_tdata[IP_W-1:0], want.ip);
                if (m_tdata[IP_W +: PORT_W] !== want.port)
                    flag_mismatch("found_port", 32'(m_tdata[IP_W +: PORT_W]),
                                  32'(want.port));
                if (m_tdata[IP_W+PORT_W +: OUT_LOAD_W] !== want.load)
                    flag_mismatch("found_load", 32'(m_tdata[IP_W+PORT_W +: OUT_LOAD_W]),
                                  32'(want.load));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        script_row_t      script [18];
        logic [REQ_W-1:0] req;
        logic [IP_W-1:0]  ip;
        logic [PORT_W-1:0] port;
        int               r;
        int               k;
        int               roll;
        int               pick;
        bit               draining;

        script = '{
            '{REQ_LOOKUP,     32'h0000_0000, 16'h0000,  1, 1'b1,
              '{ST_EMPTY,    32'h0, 16'h0, 16'h0}},
            '{REQ_DEREGISTER, 32'h0A00_0001, 16'h0050,  1, 1'b1,
              '{ST_NOTFOUND, 32'h0, 16'h0, 16'h0}},
            '{REQ_UNUSED,     32'hFFFF_FFFF, 16'hFFFF,  1, 1'b1,
              '{ST_NOTFOUND, 32'h0, 16'h0, 16'h0}},
            '{REQ_REGISTER,   32'h0000_0000, 16'h0000,  1, 1'b1,
              '{ST_OK,       32'h0, 16'h0, 16'h0}},
            '{REQ_REGISTER,   32'hFFFF_FFFF, 16'hFFFF,  1, 1'b1,
              '{ST_OK,       32'h0, 16'h0, 16'h0}},
            '{REQ_REGISTER,   32'h0000_0000, 16'h0000,  1, 1'b1,
              '{ST_DUP,      32'h0, 16'h0, 16'h0}},
            '{REQ_LOOKUP,     32'h1234_5678, 16'hABCD,  1, 1'b1,
              '{ST_OK,       32'h0, 16'h0, 16'h1}},
            '{REQ_LOOKUP,     32'h0000_0000, 16'h0000,  1, 1'b1,
              '{ST_OK,       32'hFFFF_FFFF, 16'hFFFF, 16'h1}},
            '{REQ_LOOKUP,     32'hFFFF_FFFF, 16'hFFFF,  1, 1'b1,
              '{ST_OK,       32'h0, 16'h0, 16'h2}},
            '{REQ_DEREGISTER, 32'h0000_0000, 16'h0000,  1, 1'b1,
              '{ST_OK,       32'h0, 16'h0, 16'h0}},
            '{REQ_DEREGISTER, 32'h0000_0000, 16'h0000,  1, 1'b1,
              '{ST_NOTFOUND, 32'h0, 16'h0, 16'h0}},
            '{REQ_REGISTER,   32'hC0A8_0001, 16'h1F90, 15, 1'b1,
              '{ST_OK,       32'h0, 16'h0, 16'h0}},
            '{REQ_REGISTER,   32'h0102_0304, 16'h0005,  1, 1'b1,
              '{ST_FULL,     32'h0, 16'h0, 16'h0}},
            '{REQ_REGISTER,   32'hFFFF_FFFF, 16'hFFFF,  1, 1'b1,
              '{ST_DUP,      32'h0, 16'h0, 16'h0}},
            '{REQ_LOOKUP,     32'h0000_0000, 16'h0000,  1, 1'b0, blank_reply},
            '{REQ_DEREGISTER, 32'hC0A8_0008, 16'h1F90,  1, 1'b1,
              '{ST_OK,       32'h0, 16'h0, 16'h0}},
            '{REQ_LOOKUP,     32'h0000_0000, 16'h0000,  1, 1'b0, blank_reply},
            '{REQ_UNUSED,     32'h0000_0000, 16'h0000,  1, 1'b1,
              '{ST_NOTFOUND, 32'h0, 16'h0, 16'h0}}
        };

        // Every third roster entry reuses the previous address with another
        // port, so a match has to look at both fields.
        for (k = 0; k < ROSTER_SIZE; k++)
        begin
            roster_ip[k]   = (k % 3 == 2) ? roster_ip[k - 1] : $urandom;
            roster_port[k] = PORT_W'($urandom_range(65535));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Scripted sequence.
        for (r = 0; r < $size(script); r++)
        begin
            for (k = 0; k < script[r].reps; k++)
                issue_request(script[r].req, script[r].ip + k, script[r].port,
                              script[r].typed, script[r].want);
        end

        // Soak: empty the table, register one worker and look it up again and
        // again so its load keeps climbing. Neither side idles here.
        calm = 1'b1;
        while (worker_count > 0)
            issue_request(REQ_DEREGISTER, worker_ip[0], worker_port[0], 1'b0, blank_reply);
        issue_request(REQ_REGISTER, $urandom, PORT_W'($urandom), 1'b0, blank_reply);
        repeat (SOAK_LOOKUPS)
            issue_request(REQ_LOOKUP, $urandom, PORT_W'($urandom), 1'b0, blank_reply);
        calm = 1'b0;

        // Random phase. Alternate between filling and draining the table so
        // both the full and the empty case keep coming back.
        for (k = 0; k < RANDOM_BEATS; k++)
        begin
            calm     = (k >= 900 && k < 1200);
            draining = ((k / 150) % 2) == 1;
            roll     = $urandom_range(99);
            ip       = $urandom;
            port     = PORT_W'($urandom);
            if (roll < 4)
                req = REQ_UNUSED;
            else if (roll < (draining ? 19 : 44))
            begin
                req = REQ_REGISTER;
                if ($urandom_range(3) != 0)
                begin
                    pick = $urandom_range(ROSTER_SIZE - 1);
                    ip   = roster_ip[pick];
                    port = roster_port[pick];
                end
            end
            else if (roll < (draining ? 59 : 64))
            begin
                req = REQ_DEREGISTER;
                if (worker_count > 0 && $urandom_range(3) != 0)
                begin
                    pick = $urandom_range(worker_count - 1);
                    ip   = worker_ip[pick];
                    port = worker_port[pick];
                end
                else if ($urandom_range(1) == 0)
                begin
                    pick = $urandom_range(ROSTER_SIZE - 1);
                    ip   = roster_ip[pick];
                    port = roster_port[pick];
                end
            end
            else
                req = REQ_LOOKUP;
            issue_request(req, ip, port, 1'b0, blank_reply);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain: wait for the last result, then watch for stray beats.
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
design/lllw_pkg.sv
design/lllw_cell.sv
design/lllw_ctrl.sv
design/least_loaded_worker_registry.sv
test/least_loaded_worker_registry_test.sv
